// File: rtl/core/mcfir_pkg.sv
`timescale 1ns / 1ps

package mcfir_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_TAPS        = 32;
  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_SAMPLE_BITS = 10;

  // Fixed arithmetic widths (Q15 weights, 32-bit wrapping accumulator)
  localparam int WEIGHT_BITS = 16;
  localparam int ACC_BITS    = 32;
  localparam int Q_SHIFT     = 15;
  localparam int OUT_BITS    = 16;

  // Item kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  // Per-cycle move controls shared by every cell
  typedef struct packed {
    logic samp_shift;  // samples move one cell down the ring
    logic wgt_shift;   // weights move one cell down the ring
  } cell_ctrl_t;

endpackage

// File: rtl/core/mcfir_cell.sv
`timescale 1ns / 1ps

module mcfir_cell #(
  parameter int CHANNELS    = mcfir_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mcfir_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  mcfir_pkg::cell_ctrl_t                             ctrl,
  input  logic [CHANNELS-1:0]                               wr_en,
  input  logic [mcfir_pkg::WEIGHT_BITS-1:0]                 wr_val,
  input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]              samp_in,
  input  logic [CHANNELS-1:0][mcfir_pkg::WEIGHT_BITS-1:0]   wgt_in,
  output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]              samp,
  output logic [CHANNELS-1:0][mcfir_pkg::WEIGHT_BITS-1:0]   wgt
);
  import mcfir_pkg::*;

  // One tap for every channel: a sample and a weight each
  always_ff @(posedge clk) begin
    if (rst) begin
      samp <= '0;
      wgt  <= '0;
    end else begin
      if (ctrl.samp_shift) begin
        samp <= samp_in;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (ctrl.wgt_shift) begin
          wgt[c] <= wgt_in[c];
        end else if (wr_en[c]) begin
          wgt[c] <= wr_val;
        end
      end
    end
  end

endmodule

// File: rtl/core/mcfir_mac.sv
`timescale 1ns / 1ps

module mcfir_mac #(
  parameter int CHANNELS    = mcfir_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mcfir_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              step,
  input  logic                                              last,
  input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]              samp,
  input  logic [CHANNELS-1:0][mcfir_pkg::WEIGHT_BITS-1:0]   wgt,
  output logic [CHANNELS-1:0][mcfir_pkg::OUT_BITS-1:0]      filt
);
  import mcfir_pkg::*;

  localparam int PROD_BITS = WEIGHT_BITS + SAMPLE_BITS + 1;

  logic signed [PROD_BITS-1:0]        prod [CHANNELS];
  logic [CHANNELS-1:0][ACC_BITS-1:0]  acc;
  logic [CHANNELS-1:0][ACC_BITS-1:0]  acc_next;

  // signed weight times zero-extended sample; sum wraps at 32 bits
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod[c]     = $signed(wgt[c]) * $signed({1'b0, samp[c]});
      acc_next[c] = acc[c] + ACC_BITS'(prod[c]);
      filt[c]     = acc_next[c][Q_SHIFT +: OUT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (step) begin
      acc <= last ? '0 : acc_next;
    end
  end

endmodule

// File: rtl/core/multichannel_fir_filter.sv
`timescale 1ns / 1ps

// Multichannel FIR filter, Q15 weights, one tap per cell.
// Input channel (s_*): tuser = kind. A weight item (kind 1) writes one
// weight for one channel and tap and gives no output.
// A sample item (kind 0) carries one sample per channel; it is shifted into
// the cell ring at acceptance and then TAPS multiply-accumulate steps run,
// one tap per cycle unless an output stall holds the last step, with weights
// and samples rotating past the MAC lanes. Output channel (m_*): one item
// per sample item, one filtered value per channel, the accumulator
// arithmetically shifted right by 15, low 16 bits kept; m_tvalid rises
// with the last MAC step. No new item is taken while a MAC pass runs, set
// by the single MAC lane per channel; weight items are taken only while idle.
// s_tready is high whenever no MAC pass is running, also while an output
// item still waits. If the receiver stalls, the last MAC step of the next
// pass is held until the output register is free; nothing is dropped.
// Reset clears all samples and weights to zero, empties the output
// register and leaves the block ready.
// Tap i pairs with the sample that is i places after the newest in the
// circular line; the ring keeps each sample in the cell of its tap.
module multichannel_fir_filter #(
  parameter int TAPS        = mcfir_pkg::DEF_TAPS,
  parameter int CHANNELS    = mcfir_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mcfir_pkg::DEF_SAMPLE_BITS,
  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int TAP_BITS   = $clog2(TAPS),
  localparam int IN_BITS    = CHANNELS * SAMPLE_BITS + CH_BITS + TAP_BITS
                              + mcfir_pkg::WEIGHT_BITS,
  localparam int IN_TDATA   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA  = CHANNELS * mcfir_pkg::OUT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sample_ch0..sample_chN-1, channel, tap_index, weight_value, zero pad
  input  logic [IN_TDATA-1:0]  s_tdata,
  // kind
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // filtered_ch0..filtered_chN-1
  output logic [OUT_TDATA-1:0] m_tdata
);
  import mcfir_pkg::*;

  localparam int CH_LSB  = CHANNELS * SAMPLE_BITS;
  localparam int TAP_LSB = CH_LSB + CH_BITS;
  localparam int WGT_LSB = TAP_LSB + TAP_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state;
  logic [TAP_BITS-1:0] cnt;

  logic accept, insert, wr_acc, last, step_en;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] new_samp;
  logic [CH_BITS-1:0]                   wr_ch;
  logic [TAP_BITS-1:0]                  wr_tap;
  logic [WEIGHT_BITS-1:0]               wr_val;

  cell_ctrl_t ctrl;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samp_q [TAPS];
  logic [CHANNELS-1:0][WEIGHT_BITS-1:0] wgt_q  [TAPS];
  logic [CHANNELS-1:0][OUT_BITS-1:0]    filt;

  // field unpack
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      new_samp[c] = s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end
  assign wr_ch  = s_tdata[CH_LSB  +: CH_BITS];
  assign wr_tap = s_tdata[TAP_LSB +: TAP_BITS];
  assign wr_val = s_tdata[WGT_LSB +: WEIGHT_BITS];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign insert   = accept && (s_tuser == KIND_SAMPLE);
  assign wr_acc   = accept && (s_tuser == KIND_WEIGHT);
  assign last     = (cnt == TAP_BITS'(TAPS - 1));
  // hold the final step while the previous output item is unread
  assign step_en  = (state == ST_RUN) && !(last && m_tvalid && !m_tready);

  assign ctrl.samp_shift = insert || step_en;
  assign ctrl.wgt_shift  = step_en;

  // Ring of tap cells: cell i takes from cell i+1, the last from cell 0.
  // A new sample enters cell 0 while the old tap-0 sample wraps to the end.
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int NXT = (i + 1) % TAPS;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samp_in;
    logic [CHANNELS-1:0]                  cell_wr;

    if (i == 0) begin : g_head
      assign samp_in = insert ? new_samp : samp_q[NXT];
    end else begin : g_body
      assign samp_in = samp_q[NXT];
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_wr
      assign cell_wr[c] = wr_acc && (wr_tap == TAP_BITS'(i))
                          && (wr_ch == CH_BITS'(c));
    end

    mcfir_cell #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .wr_en   (cell_wr),
      .wr_val  (wr_val),
      .samp_in (samp_in),
      .wgt_in  (wgt_q[NXT]),
      .samp    (samp_q[i]),
      .wgt     (wgt_q[i])
    );
  end

  // MAC lanes read the head of the ring
  mcfir_mac #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .step (step_en),
    .last (last),
    .samp (samp_q[0]),
    .wgt  (wgt_q[0]),
    .filt (filt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (insert) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (step_en) begin
            if (last) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + TAP_BITS'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase

      if (step_en && last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (step_en && last) begin
      for (int c = 0; c < CHANNELS; c++) begin
        m_tdata[c*OUT_BITS +: OUT_BITS] <= filt[c];
      end
    end
  end

`ifndef SYNTHESIS
  a_insert_starts: assert property (@(posedge clk) disable iff (rst)
    insert |=> (state == ST_RUN) && (cnt == '0))
    else $error("sample item did not start a MAC pass");

  a_last_step_out: assert property (@(posedge clk) disable iff (rst)
    (step_en && last) |=> m_tvalid && (state == ST_IDLE))
    else $error("final MAC step did not present an output item");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("tap counter not cleared while idle");

  a_hold_cnt: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && !step_en) |=> $stable(cnt) && (state == ST_RUN))
    else $error("MAC pass advanced during output stall");
`endif

endmodule

// File: dv/multichannel_fir_filter_test.sv
`timescale 1ns / 1ps

module multichannel_fir_filter_test;
  import mcfir_pkg::*;

  localparam int TAPS     = DEF_TAPS;
  localparam int CHANNELS = DEF_CHANNELS;
  localparam int SBITS    = DEF_SAMPLE_BITS;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int IN_W     = 64;
  localparam int OUT_W    = CHANNELS * OUT_BITS;
  localparam int ITEM_GOAL  = 1200;
  localparam int PHASE_LEN  = 300;
  localparam int STALL_CAP  = 3000;

  // Mirror of the filter: per-channel circular lines, weight store and the
  // shared write position, plus the queue of outputs still owed.
  class fir_scoreboard;
    logic [SBITS-1:0]              line_q [CHANNELS][TAPS];
    logic signed [WEIGHT_BITS-1:0] coeff  [CHANNELS][TAPS];
    logic [$clog2(TAPS)-1:0]       newest;
    logic [OUT_W-1:0]              owed [$];
    int errors;
    int checked;

    function new();
      foreach (line_q[c, t]) begin
        line_q[c][t] = '0;
        coeff[c][t]  = '0;
      end
      newest  = TAP_W'(TAPS - 1);
      errors  = 0;
      checked = 0;
    endfunction

    // Q15 dot product over the line, oldest-after-newest ordering, wrapping
    // 32-bit sum, arithmetic shift, low 16 bits kept.
    function logic [OUT_BITS-1:0] filter_out(int c);
      int acc;
      int shifted;
      logic [$clog2(TAPS)-1:0] p;
      acc = 0;
      p   = newest;
      for (int i = 0; i < TAPS; i++) begin
        acc = acc + int'(coeff[c][i]) * int'({1'b0, line_q[c][p]});
        p   = p + TAP_W'(1);
      end
      shifted = acc >>> Q_SHIFT;
      return shifted[OUT_BITS-1:0];
    endfunction

    function void note_item(logic kind, logic [IN_W-1:0] d);
      logic [OUT_W-1:0] res;
      if (kind == KIND_WEIGHT) begin
        coeff[d[CHANNELS*SBITS +: 2]][d[CHANNELS*SBITS+2 +: 5]] =
          d[CHANNELS*SBITS+7 +: WEIGHT_BITS];
      end else begin
        newest = newest + TAP_W'(1);
        for (int c = 0; c < CHANNELS; c++)
          line_q[c][newest] = d[c*SBITS +: SBITS];
        for (int c = 0; c < CHANNELS; c++)
          res[c*OUT_BITS +: OUT_BITS] = filter_out(c);
        owed.push_back(res);
      end
    endfunction

    function void check_output(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("output item %h arrived with nothing outstanding", got);
        return;
      end
      want = owed.pop_front();
      checked++;
      for (int c = 0; c < CHANNELS; c++) begin
        if (got[c*OUT_BITS +: OUT_BITS] !== want[c*OUT_BITS +: OUT_BITS]) begin
          errors++;
          if (errors <= 10)
            $display("filtered_ch%0d mismatch at output %0d: expected %0d, got %0d",
                     c, checked, $signed(want[c*OUT_BITS +: OUT_BITS]),
                     $signed(got[c*OUT_BITS +: OUT_BITS]));
        end
      end
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             s_tuser  = KIND_SAMPLE;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  fir_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_samples      = 0;
  int n_weights      = 0;
  int quiet_cycles   = 0;

  multichannel_fir_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output side: every accepted output item is checked in order.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output(m_tdata);
  end

  // Watchdog: ends the run after too long without a handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_CAP) begin
      $display("watchdog: no handshake for %0d cycles", STALL_CAP);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic push_item(input logic kind, input logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(kind, d);
    if (kind == KIND_WEIGHT) n_weights++;
    else n_samples++;
    @(negedge clk);
  endtask

  // Sample item; the weight fields carry random noise that must be ignored.
  task automatic send_samples(input logic [SBITS-1:0] s0, s1, s2, s3);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: SBITS]       = s0;
    d[SBITS +: SBITS]   = s1;
    d[2*SBITS +: SBITS] = s2;
    d[3*SBITS +: SBITS] = s3;
    d[4*SBITS +: 23]    = 23'($urandom);
    push_item(KIND_SAMPLE, d);
  endtask

  // Weight write; the sample fields carry random noise that must be ignored.
  task automatic send_weight(input logic [1:0] ch, input logic [4:0] tap,
                             input logic [WEIGHT_BITS-1:0] w);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: 4*SBITS]            = {8'($urandom), $urandom};
    d[4*SBITS +: 2]            = ch;
    d[4*SBITS+2 +: 5]          = tap;
    d[4*SBITS+7 +: WEIGHT_BITS] = w;
    push_item(KIND_WEIGHT, d);
  endtask

  // Hold the sender until every owed output has been taken.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [SBITS-1:0] pick_sample(int style);
    case (style)
      0: return '1;
      1: return '0;
      2: return $urandom_range(1) ? '1 : '0;
      default: return SBITS'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight(int style, int tap);
    case (style)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return tap[0] ? 16'h8000 : 16'h7fff;
      3: return 16'($signed($urandom_range(511)) - 256);
      4: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int style;
    int burst;
    logic [1:0] ch;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: all-zero weights, extreme weights at the ends of the line,
    // extreme and alternating samples, noise in the unused fields.
    send_samples('1, '1, '1, '1);
    send_weight(2'd0, 5'd0,  16'h7fff);
    send_weight(2'd1, 5'd31, 16'h8000);
    send_weight(2'd2, 5'd0,  16'h8000);
    send_weight(2'd3, 5'd31, 16'h7fff);
    send_weight(2'd0, 5'd31, 16'hffff);
    send_weight(2'd3, 5'd15, 16'h0001);
    send_weight(2'd1, 5'd0,  16'h0001);
    send_weight(2'd2, 5'd31, 16'h7fff);
    send_samples('1, '1, '1, '1);
    send_samples('0, '0, '0, '0);
    send_samples('1, '0, '1, '0);
    send_samples('0, '1, '0, '1);
    for (int i = 0; i < 10; i++)
      send_samples(pick_sample(i % 4), pick_sample(3), 10'd512, 10'd1);
    send_weight(2'd0, 5'd0, 16'h0000);
    send_samples('1, '1, '1, '1);

    // Random: coefficient loads, sample bursts and stray weight writes,
    // with the idling pattern changing every few hundred items.
    phase = -1;
    while (n_samples + n_weights < ITEM_GOAL) begin
      if ((n_samples + n_weights) / PHASE_LEN != phase) begin
        phase = (n_samples + n_weights) / PHASE_LEN;
        drain_outputs();
        case (phase % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
          default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
      end
      style = $urandom_range(99);
      if (style < 12) begin
        // full load of one channel's taps
        ch    = 2'($urandom);
        style = $urandom_range(5);
        for (int t = 0; t < TAPS; t++)
          send_weight(ch, 5'(t), pick_weight(style, t));
      end else if (style < 85) begin
        burst = $urandom_range(1, 12);
        style = $urandom_range(6);
        for (int i = 0; i < burst; i++)
          send_samples(pick_sample(style), pick_sample(style),
                       pick_sample(style), pick_sample(style));
      end else begin
        send_weight(2'($urandom), 5'($urandom), pick_weight($urandom_range(5), 0));
      end
    end

    drain_outputs();
    repeat (TAPS + 8) @(posedge clk);
    sb.errors += sb.owed.size();

    $display("covered %0d sample items and %0d weight writes, %0d outputs checked",
             n_samples, n_weights, sb.checked);
    $display("idling phases: none, sender gaps, receiver stalls, both; %0d failures",
             sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
